FILE: design/gka_pkg.sv
// Shared types, codes and helpers for the gamepad key autorepeat block.
package gka_pkg;

  // Input operation codes
  localparam logic [1:0] OP_AXIS       = 2'd0;
  localparam logic [1:0] OP_BUTTON     = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;
  localparam logic [1:0] OP_DISCONNECT = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEAD_ZONE       = 2'd0;
  localparam logic [1:0] CFG_REPEAT_DELAY    = 2'd1;
  localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd2;

  localparam logic [14:0] DEAD_ZONE_RST       = 15'd16000;
  localparam logic [15:0] REPEAT_DELAY_RST    = 16'd320;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd90;

  // Axis direction codes
  localparam logic [1:0] DIR_CENTRE = 2'd0;
  localparam logic [1:0] DIR_POS    = 2'd1;
  localparam logic [1:0] DIR_NEG    = 2'd2;

  // Key codes
  localparam logic [3:0] KC_LEFT    = 4'd0;
  localparam logic [3:0] KC_RIGHT   = 4'd1;
  localparam logic [3:0] KC_UP      = 4'd2;
  localparam logic [3:0] KC_DOWN    = 4'd3;
  localparam logic [3:0] KC_RETURN  = 4'd4;
  localparam logic [3:0] KC_ESCAPE  = 4'd5;
  localparam logic [3:0] KC_SPACE   = 4'd6;
  localparam logic [3:0] KC_BACKTAB = 4'd7;
  localparam logic [3:0] KC_TAB     = 4'd8;

  // Command queue depth
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_AXIS,
    CMD_KEY,
    CMD_TICK,
    CMD_CLEAR
  } cmd_kind_t;

  // One classified transaction handed from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [1:0] slot;   // axis slot 0..3 for axes 0, 1, 6, 7
    logic [1:0] dir;    // new direction for axis commands
    logic [3:0] key;    // key for button taps
    logic       shift;
  } cmd_t;

  typedef struct packed {
    logic [14:0] dead_zone;
    logic [15:0] repeat_delay;
    logic [15:0] repeat_interval;
  } cfg_t;

  // Arrow key for a slot/direction; slots 0 and 2 are horizontal.
  // Only meaningful for a non-centre direction.
  function automatic logic [3:0] axis_key(logic [1:0] slot, logic [1:0] dir);
    logic [3:0] k;
    if (slot[0] == 1'b0) begin
      k = (dir == DIR_NEG) ? KC_LEFT : KC_RIGHT;
    end else begin
      k = (dir == DIR_NEG) ? KC_UP : KC_DOWN;
    end
    return k;
  endfunction

endpackage

FILE: design/gka_front.sv
// Front end: classifies joystick transactions into queue commands.
module gka_front (
  input  logic [1:0]         operation,
  input  logic [7:0]         event_number,
  input  logic signed [15:0] event_value,
  input  logic               init_flag,
  input  logic [14:0]        dead_zone,
  output gka_pkg::cmd_t      cmd,
  output logic               cmd_keep
);
  import gka_pkg::*;

  localparam logic [7:0] AXIS_X0 = 8'd0;
  localparam logic [7:0] AXIS_Y0 = 8'd1;
  localparam logic [7:0] AXIS_X1 = 8'd6;
  localparam logic [7:0] AXIS_Y1 = 8'd7;

  localparam logic [7:0] BTN_A     = 8'd0;
  localparam logic [7:0] BTN_B     = 8'd1;
  localparam logic [7:0] BTN_X     = 8'd2;
  localparam logic [7:0] BTN_LB    = 8'd4;
  localparam logic [7:0] BTN_RB    = 8'd5;
  localparam logic [7:0] BTN_BACK  = 8'd6;

  logic signed [16:0] value_ext;
  logic signed [16:0] dz_pos;
  logic signed [16:0] dz_neg;
  logic [1:0]         new_dir;

  assign value_ext = 17'(event_value);
  assign dz_pos    = $signed({2'b00, dead_zone});
  assign dz_neg    = -dz_pos;

  always_comb begin
    if (value_ext > dz_pos) begin
      new_dir = DIR_POS;
    end else if (value_ext < dz_neg) begin
      new_dir = DIR_NEG;
    end else begin
      new_dir = DIR_CENTRE;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.dir   = new_dir;
    cmd_keep  = 1'b0;
    unique case (operation)
      OP_AXIS: begin
        cmd.kind = CMD_AXIS;
        if (!init_flag) begin
          cmd_keep = 1'b1;
          priority case (event_number)
            AXIS_X0: cmd.slot = 2'd0;
            AXIS_Y0: cmd.slot = 2'd1;
            AXIS_X1: cmd.slot = 2'd2;
            AXIS_Y1: cmd.slot = 2'd3;
            default: cmd_keep = 1'b0;
          endcase
        end
      end
      OP_BUTTON: begin
        cmd.kind = CMD_KEY;
        if (!init_flag && event_value != 16'sd0) begin
          cmd_keep = 1'b1;
          priority case (event_number)
            BTN_A:    cmd.key = KC_RETURN;
            BTN_B:    cmd.key = KC_ESCAPE;
            BTN_X:    cmd.key = KC_SPACE;
            BTN_LB: begin
              cmd.key   = KC_BACKTAB;
              cmd.shift = 1'b1;
            end
            BTN_RB:   cmd.key = KC_TAB;
            BTN_BACK: cmd.key = KC_ESCAPE;
            default:  cmd_keep = 1'b0;
          endcase
        end
      end
      OP_TICK: begin
        cmd.kind = CMD_TICK;
        cmd_keep = 1'b1;
      end
      OP_DISCONNECT: begin
        cmd.kind = CMD_CLEAR;
        cmd_keep = 1'b1;
      end
    endcase
  end

endmodule

FILE: design/gka_fifo.sv
// Short command queue between front end and back end.
module gka_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gka_pkg::cmd_t push_data,
  output logic          push_ready,
  input  logic          pop,
  output gka_pkg::cmd_t pop_data,
  output logic          pop_valid
);
  import gka_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(FIFO_DEPTH - 1);

  cmd_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != DEPTH_C);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && push_ready, pop && pop_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C) else $error("queue count over depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready) else $error("push into full queue");

endmodule

FILE: design/gka_back.sv
// Back end: axis state, repeat timer and registered key output.
module gka_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   repeat_delay,
  input  logic [15:0]   repeat_interval,
  input  logic          cmd_valid,
  input  gka_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    key_code,
  output logic          with_shift
);
  import gka_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DELAY,
    PH_REPEAT
  } phase_t;

  phase_t      phase;
  logic [15:0] ticks;
  logic [3:0]  repeat_key;
  logic [1:0]  dirs [4];

  logic [15:0] ticks_inc;
  logic [15:0] limit;
  logic [15:0] limit_eff;
  logic        tick_hit;
  logic [1:0]  old_dir;
  logic [3:0]  old_key;
  logic [3:0]  new_key;
  logic        tap_now;

  assign cmd_pop   = cmd_valid && (!out_valid || out_ready);
  assign ticks_inc = ticks + 16'd1;
  assign limit     = (phase == PH_DELAY) ? repeat_delay : repeat_interval;
  assign limit_eff = (limit == '0) ? 16'd1 : limit;
  assign tick_hit  = (ticks_inc >= limit_eff);
  assign old_dir   = dirs[cmd.slot];
  assign old_key   = axis_key(cmd.slot, old_dir);
  assign new_key   = axis_key(cmd.slot, cmd.dir);

  // A tap is loaded into the output register this cycle
  assign tap_now = cmd_pop && ((cmd.kind == CMD_KEY) ||
                   (cmd.kind == CMD_AXIS && old_dir != cmd.dir && cmd.dir != DIR_CENTRE) ||
                   (cmd.kind == CMD_TICK && phase == PH_REPEAT && tick_hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      ticks      <= '0;
      repeat_key <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        dirs[i] <= DIR_CENTRE;
      end
    end else begin
      if (tap_now) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_pop) begin
        unique case (cmd.kind)
          CMD_AXIS: begin
            if (old_dir != cmd.dir) begin
              dirs[cmd.slot] <= cmd.dir;
              if (cmd.dir != DIR_CENTRE) begin
                repeat_key <= new_key;
                phase      <= PH_DELAY;
                ticks      <= '0;
                key_code   <= new_key;
                with_shift <= 1'b0;
              end else if (old_dir != DIR_CENTRE && phase != PH_IDLE &&
                           repeat_key == old_key) begin
                repeat_key <= '0;
                phase      <= PH_IDLE;
                ticks      <= '0;
              end
            end
          end
          CMD_KEY: begin
            key_code   <= cmd.key;
            with_shift <= cmd.shift;
          end
          CMD_TICK: begin
            unique case (phase)
              PH_DELAY: begin
                ticks <= tick_hit ? '0 : ticks_inc;
                if (tick_hit) begin
                  phase <= PH_REPEAT;
                end
              end
              PH_REPEAT: begin
                ticks <= tick_hit ? '0 : ticks_inc;
                if (tick_hit) begin
                  key_code   <= repeat_key;
                  with_shift <= 1'b0;
                end
              end
              default: ;
            endcase
          end
          CMD_CLEAR: begin
            phase      <= PH_IDLE;
            ticks      <= '0;
            repeat_key <= '0;
            for (int i = 0; i < 4; i++) begin
              dirs[i] <= DIR_CENTRE;
            end
          end
        endcase
      end
    end
  end

  a_idle_ticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> ticks == '0) else $error("ticks running while idle");
  a_arrow_only: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> repeat_key <= KC_DOWN)
    else $error("repeat armed on a non-arrow key");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd.kind == CMD_CLEAR |=>
      phase == PH_IDLE && dirs[0] == DIR_CENTRE && dirs[1] == DIR_CENTRE &&
      dirs[2] == DIR_CENTRE && dirs[3] == DIR_CENTRE)
    else $error("disconnect left state behind");

endmodule

FILE: design/gamepad_key_autorepeat.sv
// Top level of the gamepad key autorepeat block.
// Takes one joystick transaction (axis, button, 1 ms tick or disconnect) per
// clock and turns it into at most one key tap. The front end decodes the
// transaction and does the dead-zone compare; a two-entry command queue feeds
// the back end, which holds the four axis directions, the repeat timer and a
// registered output. Throughput is one transaction per cycle as long as taps
// are taken; a tap that a transaction causes passes first through the queue,
// written at the accepting edge, and then into the output register. When
// the output stalls, the queue absorbs two more transactions before in_ready
// drops. Transactions that do nothing (init-flagged axis and button events,
// unmapped axes or buttons, releases) are accepted and dropped at the front.
// Configuration writes are always ready and take effect on the next cycle;
// change them only while idle.
module gamepad_key_autorepeat (
  input  logic               clk,
  input  logic               rst,
  // input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         event_number,
  input  logic signed [15:0] event_value,
  input  logic               init_flag,
  // key taps
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         key_code,
  output logic               with_shift,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import gka_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  logic front_keep;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;
  logic q_push;

  // Register file: writes beyond the last index are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone       <= DEAD_ZONE_RST;
      cfg.repeat_delay    <= REPEAT_DELAY_RST;
      cfg.repeat_interval <= REPEAT_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        CFG_DEAD_ZONE:       cfg.dead_zone       <= cfg_data[14:0];
        CFG_REPEAT_DELAY:    cfg.repeat_delay    <= cfg_data;
        CFG_REPEAT_INTERVAL: cfg.repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode and dead-zone compare
  gka_front u_front (
    .operation    (operation),
    .event_number (event_number),
    .event_value  (event_value),
    .init_flag    (init_flag),
    .dead_zone    (cfg.dead_zone),
    .cmd          (front_cmd),
    .cmd_keep     (front_keep)
  );

  // Only commands the front end keeps go into the queue
  assign q_push = in_valid && in_ready && front_keep;

  gka_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (front_cmd),
    .push_ready (in_ready),
    .pop        (q_pop),
    .pop_data   (q_cmd),
    .pop_valid  (q_valid)
  );

  // Axis state, repeat timer, output register
  gka_back u_back (
    .clk             (clk),
    .rst             (rst),
    .repeat_delay    (cfg.repeat_delay),
    .repeat_interval (cfg.repeat_interval),
    .cmd_valid       (q_valid),
    .cmd             (q_cmd),
    .cmd_pop         (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .key_code        (key_code),
    .with_shift      (with_shift)
  );

endmodule

FILE: tb/gka_tb_pkg.sv
// Tap predictor and scoreboard for the gamepad key autorepeat testbench.
package gka_tb_pkg;
  import gka_pkg::*;

  typedef enum logic [1:0] {
    REP_IDLE    = 2'd0,
    REP_WAITING = 2'd1,
    REP_RUNNING = 2'd2
  } repeat_phase_t;

  typedef struct packed {
    logic [3:0] key;
    logic       shift;
  } key_tap_t;

  class key_tap_predictor;
    logic [14:0]   dead_zone;
    logic [15:0]   repeat_delay;
    logic [15:0]   repeat_interval;
    logic [1:0]    axis_dir [4];
    logic [3:0]    held_key;
    repeat_phase_t phase;
    logic [15:0]   held_ticks;
    key_tap_t      expected_taps [$];
    int unsigned   mismatches;

    function new();
      dead_zone       = DEAD_ZONE_RST;
      repeat_delay    = REPEAT_DELAY_RST;
      repeat_interval = REPEAT_INTERVAL_RST;
      mismatches      = 0;
      clear();
    endfunction

    function void clear();
      foreach (axis_dir[i]) axis_dir[i] = DIR_CENTRE;
      held_key   = KC_LEFT;
      phase      = REP_IDLE;
      held_ticks = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_DEAD_ZONE:       dead_zone       = data[14:0];
        CFG_REPEAT_DELAY:    repeat_delay    = data;
        CFG_REPEAT_INTERVAL: repeat_interval = data;
        default: ;
      endcase
    endfunction

    function logic [3:0] arrow_for(int slot, logic [1:0] dir);
      if (slot == 0 || slot == 2) return (dir == DIR_NEG) ? KC_LEFT : KC_RIGHT;
      return (dir == DIR_NEG) ? KC_UP : KC_DOWN;
    endfunction

    function void push_tap(logic [3:0] key, logic shift);
      key_tap_t t;
      t.key   = key;
      t.shift = shift;
      expected_taps.push_back(t);
    endfunction

    function void axis_event(logic [7:0] num, logic signed [15:0] val);
      int         slot;
      int         pos;
      int         dz;
      logic [1:0] old_dir;
      logic [1:0] new_dir;
      case (num)
        8'd0:    slot = 0;
        8'd1:    slot = 1;
        8'd6:    slot = 2;
        8'd7:    slot = 3;
        default: slot = -1;
      endcase
      if (slot < 0) return;
      pos = int'(val);
      dz  = int'(dead_zone);
      if (pos > dz)       new_dir = DIR_POS;
      else if (pos < -dz) new_dir = DIR_NEG;
      else                new_dir = DIR_CENTRE;
      old_dir = axis_dir[slot];
      if (old_dir == new_dir) return;
      axis_dir[slot] = new_dir;
      if (new_dir != DIR_CENTRE) begin
        held_key   = arrow_for(slot, new_dir);
        phase      = REP_WAITING;
        held_ticks = '0;
        push_tap(held_key, 1'b0);
      end else if (old_dir != DIR_CENTRE && phase != REP_IDLE &&
                   held_key == arrow_for(slot, old_dir)) begin
        // only the axis owning the repeat may cancel it
        held_key   = KC_LEFT;
        phase      = REP_IDLE;
        held_ticks = '0;
      end
    endfunction

    function void button_event(logic [7:0] num, logic signed [15:0] val);
      if (val == 16'sd0) return;
      case (num)
        8'd0: push_tap(KC_RETURN, 1'b0);
        8'd1: push_tap(KC_ESCAPE, 1'b0);
        8'd2: push_tap(KC_SPACE, 1'b0);
        8'd4: push_tap(KC_BACKTAB, 1'b1);
        8'd5: push_tap(KC_TAB, 1'b0);
        8'd6: push_tap(KC_ESCAPE, 1'b0);
        default: ;
      endcase
    endfunction

    function void tick();
      logic [15:0] limit;
      if (phase == REP_WAITING) begin
        limit      = (repeat_delay == 16'd0) ? 16'd1 : repeat_delay;
        held_ticks = held_ticks + 16'd1;
        if (held_ticks >= limit) begin
          phase      = REP_RUNNING;
          held_ticks = '0;
        end
      end else if (phase == REP_RUNNING) begin
        limit      = (repeat_interval == 16'd0) ? 16'd1 : repeat_interval;
        held_ticks = held_ticks + 16'd1;
        if (held_ticks >= limit) begin
          held_ticks = '0;
          push_tap(held_key, 1'b0);
        end
      end
    endfunction

    // Called once per accepted input transaction.
    function void note_event(logic [1:0] op, logic [7:0] num, logic signed [15:0] val,
                             logic init);
      case (op)
        OP_AXIS:   if (!init) axis_event(num, val);
        OP_BUTTON: if (!init) button_event(num, val);
        OP_TICK:   tick();
        default:   clear();
      endcase
    endfunction

    // Called once per accepted output transaction.
    function void check_tap(logic [3:0] key, logic shift);
      key_tap_t want;
      if (expected_taps.size() == 0) begin
        mismatches++;
        $error("tap with none expected: key_code %0d with_shift %0d", key, shift);
        return;
      end
      want = expected_taps.pop_front();
      if (key !== want.key) begin
        mismatches++;
        $error("key_code: expected %0d, actual %0d", want.key, key);
      end
      if (shift !== want.shift) begin
        mismatches++;
        $error("with_shift: expected %0d, actual %0d", want.shift, shift);
      end
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
// Top-level testbench for the gamepad key autorepeat block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gka_pkg::*;
  import gka_tb_pkg::*;

  // Index 3 maps to no register; a write there must change nothing.
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         ITEMS_PER_PHASE = 140;
  localparam int         NUM_PHASES  = 8;
  // Queue register plus output register, with margin for dropped transactions.
  localparam int         SETTLE_CYCLES = 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = OP_TICK;
  logic [7:0]         event_number = '0;
  logic signed [15:0] event_value = '0;
  logic               init_flag = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         key_code;
  logic               with_shift;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_DEAD_ZONE;
  logic [15:0]        cfg_data = '0;

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;

  key_tap_predictor taps;

  gamepad_key_autorepeat i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .event_number (event_number),
    .event_value  (event_value),
    .init_flag    (init_flag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_code     (key_code),
    .with_shift   (with_shift),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Output side backpressure: stall about one cycle in five unless steady.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 20);
  end

  // Every tap transaction is checked against the oldest predicted tap.
  // Sampling at the edge sees pre-edge values of valid and ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) taps.check_tap(key_code, with_shift);
  end

  // Hard stop in case the block hangs or taps go missing.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // One input transaction: optional idle gap, then hold valid until taken.
  // Valid is never dropped between back-to-back transactions.
  task automatic send_event(input logic [1:0] op, input logic [7:0] num,
                            input logic signed [15:0] val, input logic init);
    if (!steady) begin
      while ($urandom_range(0, 99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    operation    <= op;
    event_number <= num;
    event_value  <= val;
    init_flag    <= init;
    do @(posedge clk); while (!in_ready);
    taps.note_event(op, num, val, init);
  endtask

  // Register write; cfg_valid stays high so a batch runs back to back.
  // The caller drops cfg_valid after the last write of a batch.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    taps.write_reg(idx, data);
  endtask

  // Stop input, wait for every predicted tap, then let dropped
  // transactions still in the queue drain out.
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    while (taps.expected_taps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Axis positions clustered on both sides of the dead-zone edges,
  // plus centre and fully random values.
  function automatic logic signed [15:0] axis_value(int dz);
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = dz;
      2: v = -dz;
      3: v = (dz < 32767) ? int'($urandom_range(dz + 1, 32767)) : 32767;
      4: v = -int'($urandom_range(dz + 1, 32768));
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  // Mostly ticks and mapped axes so repeats get armed, fire and get
  // cancelled; the rest is buttons, stray indexes and disconnects.
  task automatic send_random_event();
    int                 pick;
    logic [1:0]         op;
    logic [7:0]         num;
    logic signed [15:0] val;
    logic               init;
    pick = $urandom_range(0, 99);
    init = ($urandom_range(0, 99) < 5);
    num  = 8'($urandom);
    val  = 16'($urandom);
    if (pick < 42) begin
      op = OP_TICK;
    end else if (pick < 75) begin
      op = OP_AXIS;
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 3))
          0:       num = 8'd0;
          1:       num = 8'd1;
          2:       num = 8'd6;
          default: num = 8'd7;
        endcase
      end
      val = axis_value(int'(taps.dead_zone));
    end else if (pick < 97) begin
      op = OP_BUTTON;
      if ($urandom_range(0, 99) < 85) num = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 20) val = '0;
    end else begin
      op = OP_DISCONNECT;
    end
    send_event(op, num, val, init);
  endtask

  initial begin : stimulus
    int          phase_no;
    logic [15:0] dz;
    logic [15:0] dly;
    logic [15:0] ivl;

    taps = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset settings (dead zone 16000).
    send_event(OP_AXIS,   8'd0,   16'sd32767,  1'b1); // init flag: ignored
    send_event(OP_BUTTON, 8'd0,   16'sd1,      1'b1); // init flag: ignored
    send_event(OP_AXIS,   8'd3,   -16'sd32768, 1'b0); // unmapped axis
    send_event(OP_AXIS,   8'd255, 16'sd32767,  1'b0); // unmapped axis
    send_event(OP_AXIS,   8'd0,   -16'sd32768, 1'b0); // left, arms repeat
    send_event(OP_AXIS,   8'd0,   16'sd16000,  1'b0); // on the edge: centre, cancels
    send_event(OP_AXIS,   8'd1,   16'sd16001,  1'b0); // down
    send_event(OP_AXIS,   8'd6,   -16'sd16001, 1'b0); // left takes the repeat
    send_event(OP_AXIS,   8'd1,   16'sd0,      1'b0); // centre, other key repeats
    send_event(OP_BUTTON, 8'd0,   16'sd1,      1'b0);
    send_event(OP_BUTTON, 8'd1,   -16'sd32768, 1'b0);
    send_event(OP_BUTTON, 8'd2,   16'sd1,      1'b0);
    send_event(OP_BUTTON, 8'd3,   16'sd1,      1'b0); // unmapped button
    send_event(OP_BUTTON, 8'd4,   16'sd32767,  1'b0); // shifted backtab
    send_event(OP_BUTTON, 8'd5,   16'sd2,      1'b0);
    send_event(OP_BUTTON, 8'd6,   -16'sd1,     1'b0);
    send_event(OP_BUTTON, 8'd0,   16'sd0,      1'b0); // release
    send_event(OP_TICK,   8'd0,   16'sd0,      1'b1); // init flag has no effect here
    send_event(OP_DISCONNECT, 8'd0, 16'sd0,    1'b1);
    send_event(OP_TICK,   8'd0,   16'sd0,      1'b0); // tick while idle
    wait_until_quiet();

    // Zero delay and interval behave as one; dead zone at its floor.
    write_reg(CFG_DEAD_ZONE, 16'd0);
    write_reg(CFG_REPEAT_DELAY, 16'd0);
    write_reg(CFG_REPEAT_INTERVAL, 16'd0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_event(OP_AXIS,   8'd0,   16'sd1,      1'b0); // right
    send_event(OP_TICK,   8'd0,   16'sd0,      1'b0); // delay done
    send_event(OP_TICK,   8'd0,   16'sd0,      1'b0); // repeated right
    send_event(OP_AXIS,   8'd0,   16'sd0,      1'b0); // centre cancels
    send_event(OP_AXIS,   8'd7,   -16'sd1,     1'b0); // up
    send_event(OP_DISCONNECT, 8'd0, 16'sd0,    1'b0);
    send_event(OP_TICK,   8'd0,   16'sd0,      1'b0);

    // Random phases, each with its own register settings.
    for (phase_no = 0; phase_no < NUM_PHASES; phase_no++) begin
      wait_until_quiet();
      case (phase_no)
        0: begin
          dz  = 16'h7FFF;
          dly = 16'hFFFF;
          ivl = 16'hFFFF;
        end
        1: begin
          dz  = 16'd0;
          dly = 16'd1;
          ivl = 16'd1;
        end
        2: begin
          dz  = 16'($urandom);   // top bit is dropped by the register
          dly = 16'd0;
          ivl = 16'd0;
        end
        default: begin
          dz  = 16'($urandom_range(0, 30000));
          dly = 16'($urandom_range(1, 16));
          ivl = 16'($urandom_range(1, 8));
        end
      endcase
      write_reg(CFG_DEAD_ZONE, dz);
      write_reg(CFG_REPEAT_DELAY, dly);
      write_reg(CFG_REPEAT_INTERVAL, ivl);
      if (phase_no == 3) write_reg(CFG_UNUSED, 16'($urandom));
      cfg_valid <= 1'b0;
      steady = (phase_no == 4);
      repeat (ITEMS_PER_PHASE) send_random_event();
    end
    steady = 1'b0;
    wait_until_quiet();

    if (taps.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
